>>> rtl/core/pbsr_pkg.sv
// Package for the picture buffer slot replacer.
// Holds the sizes, slot kind codes and controller/datapath interface types.
// Depends on nothing.
package pbsr_pkg;

   localparam int SLOT_COUNT  = 4;
   localparam int ORDER_WIDTH = 16;
   localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [1:0] KIND_UNUSED = 2'd0;
   localparam logic [1:0] KIND_SHORT  = 2'd1;
   localparam logic [1:0] KIND_LONG   = 2'd2;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } pbsr_cmd_type;

   typedef struct packed {
      logic last;
   } pbsr_status_type;

endpackage

>>> rtl/core/picture_buffer_slot_replacer_unit.sv
// Top level of the picture buffer slot replacer.
// Joins the controller pbsr_ctrl and the datapath pbsr_datapath; uses pbsr_pkg.
//
// A picture word (req_order_count, req_picture_kind) is taken at a rising edge
// where start is high and busy is low. The block then scans its slot table one
// slot per cycle, writes the chosen slot in the commit state, and shows the
// result word on the rsp_ ports for exactly one cycle with rsp_valid high, in
// the cycle after the commit state. Busy is low again in that same cycle, so
// a new picture can be taken at the edge that ends it. No new picture is taken
// while a word is still being scanned or committed.
// The receiver cannot stall; it must take each result word in its one cycle.
// A synchronous reset marks every slot unused with an order count of minus one,
// clears any word in progress and drops busy and rsp_valid.
module picture_buffer_slot_replacer_unit
   import pbsr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [ORDER_WIDTH-1:0] req_order_count,
   input  logic                          req_picture_kind,
   output logic                          rsp_valid,
   output logic                          rsp_stored,
   output logic [1:0]                    rsp_slot_index,
   output logic                          rsp_evicted,
   output logic signed [ORDER_WIDTH-1:0] rsp_evicted_order_count
);

   pbsr_cmd_type    cmd;
   pbsr_status_type status;

   pbsr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   pbsr_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_order_count         (req_order_count),
      .req_picture_kind        (req_picture_kind),
      .rsp_valid               (rsp_valid),
      .rsp_stored              (rsp_stored),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_evicted             (rsp_evicted),
      .rsp_evicted_order_count (rsp_evicted_order_count)
   );

endmodule

>>> rtl/core/pbsr_ctrl.sv
// Controller state machine of the picture buffer slot replacer.
// Sequences load, slot scan and commit; depends on pbsr_pkg.
module pbsr_ctrl
   import pbsr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output pbsr_cmd_type    cmd,
   input  pbsr_status_type status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/pbsr_datapath.sv
// Datapath of the picture buffer slot replacer: slot table, one-slot-per-cycle
// scan for a free slot and the oldest short-term picture, and result registers.
// Depends on pbsr_pkg.
module pbsr_datapath
   import pbsr_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  pbsr_cmd_type                  cmd,
   output pbsr_status_type               status,
   input  logic signed [ORDER_WIDTH-1:0] req_order_count,
   input  logic                          req_picture_kind,
   output logic                          rsp_valid,
   output logic                          rsp_stored,
   output logic [1:0]                    rsp_slot_index,
   output logic                          rsp_evicted,
   output logic signed [ORDER_WIDTH-1:0] rsp_evicted_order_count
);

   logic signed [ORDER_WIDTH-1:0] slot_oc_ff [SLOT_COUNT];
   logic [1:0]                    slot_kind_ff [SLOT_COUNT];

   logic signed [ORDER_WIDTH-1:0] oc_ff;
   logic                          long_ff;
   logic [SLOT_BITS-1:0]          idx_ff;
   logic                          have_free_ff;
   logic [SLOT_BITS-1:0]          free_idx_ff;
   logic                          have_short_ff;
   logic [SLOT_BITS-1:0]          best_idx_ff;
   logic signed [ORDER_WIDTH-1:0] best_oc_ff;

   logic                          valid_ff;
   logic                          stored_ff;
   logic [1:0]                    slot_index_ff;
   logic                          evicted_ff;
   logic signed [ORDER_WIDTH-1:0] evicted_oc_ff;

   logic [1:0]                    cur_kind;
   logic signed [ORDER_WIDTH-1:0] cur_oc;
   logic                          take_free;
   logic                          take_short;
   logic [SLOT_BITS-1:0]          target;
   logic                          stored_in;
   logic [SLOT_BITS+1:0]          target_wide;

   assign cur_kind   = slot_kind_ff[idx_ff];
   assign cur_oc     = slot_oc_ff[idx_ff];
   assign take_free  = (cur_kind == KIND_UNUSED) && !have_free_ff;
   assign take_short = (cur_kind == KIND_SHORT) && (!have_short_ff || (cur_oc < best_oc_ff));
   assign target      = have_free_ff ? free_idx_ff : best_idx_ff;
   assign stored_in   = have_free_ff || have_short_ff;
   assign target_wide = {2'b00, target};
   assign status.last = (idx_ff == SLOT_BITS'(SLOT_COUNT - 1));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         oc_ff         <= req_order_count;
         long_ff       <= req_picture_kind;
         idx_ff        <= '0;
         have_free_ff  <= 1'b0;
         have_short_ff <= 1'b0;
      end else if (cmd.scan) begin
         if (take_free) begin
            have_free_ff <= 1'b1;
            free_idx_ff  <= idx_ff;
         end
         if (take_short) begin
            have_short_ff <= 1'b1;
            best_idx_ff   <= idx_ff;
            best_oc_ff    <= cur_oc;
         end
         if (!status.last) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
      if (cmd.commit) begin
         stored_ff     <= stored_in;
         slot_index_ff <= stored_in ? target_wide[1:0] : 2'b00;
         evicted_ff    <= !have_free_ff && have_short_ff;
         evicted_oc_ff <= (!have_free_ff && have_short_ff) ? best_oc_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_oc_ff[i]   <= '1;
            slot_kind_ff[i] <= KIND_UNUSED;
         end
      end else begin
         valid_ff <= cmd.commit;
         if (cmd.commit && stored_in) begin
            slot_oc_ff[target]   <= oc_ff;
            slot_kind_ff[target] <= long_ff ? KIND_LONG : KIND_SHORT;
         end
      end
   end

   assign rsp_valid               = valid_ff;
   assign rsp_stored              = stored_ff;
   assign rsp_slot_index          = slot_index_ff;
   assign rsp_evicted             = evicted_ff;
   assign rsp_evicted_order_count = evicted_oc_ff;

endmodule

>>> verif/picture_buffer_slot_replacer_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for picture_buffer_slot_replacer_unit: drives picture words
// into the slot table and compares every result word with a predicted slot outcome.
// Depends on pbsr_pkg and the picture_buffer_slot_replacer_unit RTL.
module picture_buffer_slot_replacer_unit_test;
   import pbsr_pkg::*;

   localparam int   CYCLE_LIMIT = 200000;
   localparam int   DRAIN_CYCLES = 2 * (SLOT_COUNT + 2) + 4;
   localparam logic PIC_SHORT = 1'b0;
   localparam logic PIC_LONG  = 1'b1;

   typedef struct packed {
      logic                          stored;
      logic [1:0]                    slot_index;
      logic                          evicted;
      logic signed [ORDER_WIDTH-1:0] evicted_order_count;
   } slot_outcome_type;

   class picture_table_tracker;
      logic signed [ORDER_WIDTH-1:0] held_order [SLOT_COUNT];
      logic [1:0]                    held_kind [SLOT_COUNT];
      slot_outcome_type              awaited_outcomes [$];
      int pictures_taken;
      int words_checked;
      int evictions;
      int drops;
      int mismatches;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            held_order[i] = '1;
            held_kind[i]  = KIND_UNUSED;
         end
         pictures_taken = 0;
         words_checked  = 0;
         evictions      = 0;
         drops          = 0;
         mismatches     = 0;
      endfunction

      function int long_count();
         int n;
         n = 0;
         for (int i = 0; i < SLOT_COUNT; i++)
            if (held_kind[i] == KIND_LONG) n++;
         return n;
      endfunction

      function int pending();
         return awaited_outcomes.size();
      endfunction

      // Free slot first; otherwise the oldest short-term picture, lowest index on ties.
      function void note_picture(logic signed [ORDER_WIDTH-1:0] order_count, logic kind);
         int                            target;
         logic                          found_short;
         logic signed [ORDER_WIDTH-1:0] lowest;
         slot_outcome_type              outcome;
         target      = -1;
         found_short = 1'b0;
         lowest      = '0;
         outcome     = '0;
         for (int i = 0; i < SLOT_COUNT; i++)
            if (target < 0 && held_kind[i] == KIND_UNUSED) target = i;
         if (target < 0) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (held_kind[i] == KIND_SHORT && (!found_short || held_order[i] < lowest)) begin
                  found_short = 1'b1;
                  lowest      = held_order[i];
                  target      = i;
               end
            end
            if (found_short) begin
               outcome.evicted             = 1'b1;
               outcome.evicted_order_count = lowest;
               evictions++;
            end
         end
         if (target >= 0) begin
            held_order[target] = order_count;
            held_kind[target]  = kind ? KIND_LONG : KIND_SHORT;
            outcome.stored     = 1'b1;
            outcome.slot_index = 2'(target);
         end else begin
            drops++;
         end
         pictures_taken++;
         awaited_outcomes.push_back(outcome);
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         if (mismatches <= 50)
            $display("MISMATCH %s on result word %0d: got %0h, want %0h",
                     what, words_checked, got, want);
      endtask

      task check_outcome(logic stored, logic [1:0] slot_index, logic evicted,
                         logic signed [ORDER_WIDTH-1:0] evicted_order_count);
         slot_outcome_type want;
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("unexpected word", 32'(slot_index), 32'(0));
         end else begin
            want = awaited_outcomes.pop_front();
            if (stored !== want.stored)
               report_mismatch("stored", 32'(stored), 32'(want.stored));
            if (slot_index !== want.slot_index)
               report_mismatch("slot_index", 32'(slot_index), 32'(want.slot_index));
            if (evicted !== want.evicted)
               report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
            if (evicted_order_count !== want.evicted_order_count)
               report_mismatch("evicted_order_count", 32'(evicted_order_count),
                               32'(want.evicted_order_count));
         end
         words_checked++;
      endtask
   endclass

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [ORDER_WIDTH-1:0] req_order_count;
   logic                          req_picture_kind;
   logic                          rsp_valid;
   logic                          rsp_stored;
   logic [1:0]                    rsp_slot_index;
   logic                          rsp_evicted;
   logic signed [ORDER_WIDTH-1:0] rsp_evicted_order_count;

   picture_table_tracker book;
   int cycle_count = 0;

   picture_buffer_slot_replacer_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_order_count         (req_order_count),
      .req_picture_kind        (req_picture_kind),
      .rsp_valid               (rsp_valid),
      .rsp_stored              (rsp_stored),
      .rsp_slot_index          (rsp_slot_index),
      .rsp_evicted             (rsp_evicted),
      .rsp_evicted_order_count (rsp_evicted_order_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d result words outstanding.",
                  cycle_count, book.pending());
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0)
         book.check_outcome(rsp_stored, rsp_slot_index, rsp_evicted, rsp_evicted_order_count);
   end

   function automatic logic signed [ORDER_WIDTH-1:0] pick_order_count();
      int unsigned roll;
      roll = $urandom_range(0, 7);
      if (roll < 3)
         return ORDER_WIDTH'($urandom_range(0, 7)) - ORDER_WIDTH'(4);
      if (roll == 3) begin
         case ($urandom_range(0, 3))
            0:       return {1'b1, {(ORDER_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(ORDER_WIDTH-1){1'b1}}};
            2:       return '0;
            default: return '1;
         endcase
      end
      return ORDER_WIDTH'($urandom);
   endfunction

   // Leaves start high after the accepting edge, so a following word can go out at once.
   task automatic send_picture(input logic signed [ORDER_WIDTH-1:0] order_count,
                               input logic kind);
      start            <= 1'b1;
      req_order_count  <= order_count;
      req_picture_kind <= kind;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      book.note_picture(order_count, kind);
   endtask

   task automatic idle_sender(input int idle_percent);
      while ($urandom_range(0, 99) < idle_percent) begin
         start            <= 1'b0;
         req_order_count  <= ORDER_WIDTH'($urandom);
         req_picture_kind <= 1'($urandom);
         @(posedge clock);
      end
   endtask

   // Long-term pictures never leave the table, so their number is capped per phase.
   task automatic run_random_phase(input int words, input int idle_percent, input int long_cap);
      logic kind;
      repeat (words) begin
         idle_sender(idle_percent);
         kind = (book.long_count() < long_cap && $urandom_range(0, 31) == 0) ? PIC_LONG
                                                                             : PIC_SHORT;
         send_picture(pick_order_count(), kind);
      end
   endtask

   initial begin
      book             = new();
      reset            <= 1'b1;
      start            <= 1'b0;
      req_order_count  <= '0;
      req_picture_kind <= PIC_SHORT;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_picture({1'b1, {(ORDER_WIDTH-1){1'b0}}}, PIC_LONG);
      send_picture({1'b0, {(ORDER_WIDTH-1){1'b1}}}, PIC_SHORT);
      send_picture('0, PIC_SHORT);
      send_picture('1, PIC_SHORT);
      send_picture(ORDER_WIDTH'(5), PIC_SHORT);
      send_picture(ORDER_WIDTH'(5), PIC_SHORT);
      send_picture({1'b0, {(ORDER_WIDTH-1){1'b1}}}, PIC_SHORT);
      send_picture({1'b0, {(ORDER_WIDTH-1){1'b1}}}, PIC_SHORT);
      send_picture({1'b1, {(ORDER_WIDTH-1){1'b0}}}, PIC_SHORT);
      send_picture({1'b1, {(ORDER_WIDTH-1){1'b0}}}, PIC_SHORT);
      send_picture({1'b0, {(ORDER_WIDTH-1){1'b1}}}, PIC_SHORT);
      send_picture(-ORDER_WIDTH'(2), PIC_SHORT);
      send_picture({(ORDER_WIDTH/2){2'b01}}, PIC_SHORT);
      send_picture({(ORDER_WIDTH/2){2'b10}}, PIC_SHORT);

      run_random_phase(200, 31, 2);
      run_random_phase(200, 46, 2);
      run_random_phase(200, 0, 2);

      while (book.long_count() < SLOT_COUNT) begin
         idle_sender(31);
         send_picture(pick_order_count(), PIC_LONG);
      end
      send_picture({1'b1, {(ORDER_WIDTH-1){1'b0}}}, PIC_SHORT);
      send_picture({1'b0, {(ORDER_WIDTH-1){1'b1}}}, PIC_LONG);
      send_picture('0, PIC_SHORT);
      send_picture('1, PIC_LONG);
      start <= 1'b0;

      while (book.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d picture words and checked %0d result words in %0d cycles.",
               book.pictures_taken, book.words_checked, cycle_count);
      $display("The table saw %0d short-term evictions and %0d dropped pictures.",
               book.evictions, book.drops);
      if (book.mismatches == 0 && book.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
